@@ hw/rtl/rce_pkg.sv @@
// Package for the reference-counted entry cache: sizes, codes, payload and control types.
package rce_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int COUNT_BITS = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NUM_W      = 16;
    localparam int IDX_W      = 5;

    typedef enum logic [1:0] {
        CMD_ACQUIRE   = 2'd0,
        CMD_DUPLICATE = 2'd1,
        CMD_RELEASE   = 2'd2,
        CMD_MARK      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_COMMIT,
        S_READ,
        S_EVAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [NUM_W-1:0]   object_number;
        logic [IDX_W-1:0]   slot_index;
        logic               links_zero;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   result_slot;
        logic               found_existing;
        logic               needs_load;
        logic               destroy;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic [NUM_W-1:0]      number;
        logic [COUNT_BITS-1:0] count;
        logic                  mark;
    } t_entry;

    typedef struct packed {
        logic                  hit;
        logic                  free;
        logic                  at_max;
        logic                  is_one;
        logic [COUNT_BITS-1:0] cnt_inc;
        logic [COUNT_BITS-1:0] cnt_dec;
    } t_unit_flags;

endpackage

@@ hw/rtl/rce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rce_unit.sv @@
// Shared compare and count unit: key match, free test, limit tests, increment, decrement.
module rce_unit (
    input  rce_pkg::t_entry              i_entry,
    input  logic [rce_pkg::NUM_W-1:0]    i_key,
    output rce_pkg::t_unit_flags         o_flags
);
    import rce_pkg::*;

    logic cnt_zero;

    assign cnt_zero        = (i_entry.count == '0);
    assign o_flags.hit     = !cnt_zero && (i_entry.number == i_key);
    assign o_flags.free    = cnt_zero;
    assign o_flags.at_max  = &i_entry.count;
    assign o_flags.is_one  = (i_entry.count == COUNT_BITS'(1));
    assign o_flags.cnt_inc = i_entry.count + COUNT_BITS'(1);
    assign o_flags.cnt_dec = i_entry.count - COUNT_BITS'(1);

endmodule

@@ hw/rtl/refcounted_entry_cache.sv @@
// Top level of the reference-counted entry cache: sequencer, slot table and output register.
//
//  channel  | valid        | stall        | payload                | direction
//  ---------+--------------+--------------+------------------------+----------
//  command  | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)  | in
//  result   | o_out_valid  | i_out_stall  | o_out_data (t_out_item) | out
//
// For an acquire, the sequencer walks every slot through the single RAM read port and the
// shared compare unit, then commits and emits. Duplicate, release and mark-loaded step
// through read, evaluate and emit; with an out-of-range slot index they go straight to emit.
// Reset is synchronous and active low; it clears all slot valid bits, so every slot reads
// as free with a clear loaded mark, and no clearing pass is needed.
// A stalled result holds in the output register; the next command is taken meanwhile and
// its result waits in the emit step until the register frees up.
module refcounted_entry_cache (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rce_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rce_pkg::t_out_item  o_out_data
);
    import rce_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer state and the held command.
    t_state              r_state, n_state;
    t_in_item            r_in, n_in;
    logic [SLOT_W-1:0]   r_ptr, n_ptr;
    logic                r_rd_pend, n_rd_pend;
    logic [SLOT_W-1:0]   r_rd_addr;

    // Scan findings: first matching slot and first free slot.
    logic                r_hit, n_hit;
    logic [SLOT_W-1:0]   r_hit_slot, n_hit_slot;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic                r_hit_mark, n_hit_mark;
    logic                r_free, n_free;
    logic [SLOT_W-1:0]   r_free_slot, n_free_slot;

    // Result staging and output register.
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // Per-slot valid bits; an invalid slot reads as count zero, mark clear.
    logic [SLOT_COUNT-1:0] r_valid;
    logic                valid_set;
    logic [SLOT_W-1:0]   valid_idx;

    // RAM and shared unit hookup.
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    t_entry              unit_entry;
    t_unit_flags         flags;

    logic [SLOT_W-1:0]   held_slot;
    logic                in_range;
    logic                rel_destroy;
    logic                rel_mark;

    rce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rce_unit u_unit (
        .i_entry (unit_entry),
        .i_key   (r_in.object_number),
        .o_flags (flags)
    );

    assign held_slot = SLOT_W'(r_in.slot_index);
    assign in_range  = (int'(i_in_data.slot_index) < SLOT_COUNT);
    assign rd_entry  = r_valid[r_rd_addr] ? t_entry'(ram_rdata) : t_entry'('0);

    // Feed the commit step from the held match; otherwise from the RAM read.
    assign unit_entry = (r_state == S_COMMIT) ?
                        {r_in.object_number, r_hit_cnt, r_hit_mark} : rd_entry;

    // Release: drop the loaded mark only when the last reference of a loaded,
    // unlinked object goes away.
    assign rel_destroy = flags.is_one && rd_entry.mark && r_in.links_zero;
    assign rel_mark    = rel_destroy ? 1'b0 : rd_entry.mark;

    assign ram_raddr   = (r_state == S_SCAN) ? r_ptr : held_slot;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_ptr       = r_ptr;
        n_rd_pend   = r_rd_pend;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_hit_cnt   = r_hit_cnt;
        n_hit_mark  = r_hit_mark;
        n_free      = r_free;
        n_free_slot = r_free_slot;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_waddr   = held_slot;
        ram_wdata   = rd_entry;
        valid_set   = 1'b0;
        valid_idx   = held_slot;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in      = i_in_data;
                    n_ptr     = '0;
                    n_rd_pend = 1'b0;
                    n_hit     = 1'b0;
                    n_free    = 1'b0;
                    if (i_in_data.command == CMD_ACQUIRE) begin
                        n_state = S_SCAN;
                    end else if (!in_range) begin
                        n_res   = '{result_slot: i_in_data.slot_index, found_existing: 1'b0,
                                    needs_load: 1'b0, destroy: 1'b0, status: ST_NOT_USED};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end

            S_SCAN, S_TAIL: begin
                // In scan, issue the next slot read; in both states, test the one that came back.
                if (r_state == S_SCAN) begin
                    n_rd_pend = 1'b1;
                    n_ptr     = r_ptr + SLOT_W'(1);
                    if (r_ptr == SLOT_W'(SLOT_COUNT - 1)) begin
                        n_state = S_TAIL;
                    end
                end else begin
                    n_rd_pend = 1'b0;
                    n_state   = S_COMMIT;
                end
                if (r_rd_pend) begin
                    if (flags.hit && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_slot = r_rd_addr;
                        n_hit_cnt  = rd_entry.count;
                        n_hit_mark = rd_entry.mark;
                    end
                    if (flags.free && !r_free) begin
                        n_free      = 1'b1;
                        n_free_slot = r_rd_addr;
                    end
                end
            end

            S_COMMIT: begin
                if (r_hit) begin
                    n_res = '{result_slot: IDX_W'(r_hit_slot), found_existing: 1'b1,
                              needs_load: !r_hit_mark, destroy: 1'b0,
                              status: flags.at_max ? ST_OVERFLOW : ST_OK};
                    if (!flags.at_max) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hit_slot;
                        ram_wdata = '{number: r_in.object_number, count: flags.cnt_inc,
                                      mark: r_hit_mark};
                    end
                end else if (r_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_free_slot;
                    ram_wdata = '{number: r_in.object_number, count: COUNT_BITS'(1),
                                  mark: 1'b0};
                    valid_set = 1'b1;
                    valid_idx = r_free_slot;
                    n_res = '{result_slot: IDX_W'(r_free_slot), found_existing: 1'b0,
                              needs_load: 1'b1, destroy: 1'b0, status: ST_OK};
                end else begin
                    n_res = '{result_slot: '0, found_existing: 1'b0, needs_load: 1'b0,
                              destroy: 1'b0, status: ST_FULL};
                end
                n_state = S_EMIT;
            end

            S_READ: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                n_res = '{result_slot: r_in.slot_index, found_existing: 1'b0,
                          needs_load: !rd_entry.mark, destroy: 1'b0, status: ST_OK};
                if (flags.free) begin
                    n_res.status = ST_NOT_USED;
                end else begin
                    case (r_in.command)
                        CMD_DUPLICATE: begin
                            if (flags.at_max) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                ram_we          = 1'b1;
                                ram_wdata.count = flags.cnt_inc;
                            end
                        end
                        CMD_RELEASE: begin
                            ram_we           = 1'b1;
                            ram_wdata.count  = flags.cnt_dec;
                            ram_wdata.mark   = rel_mark;
                            n_res.needs_load = !rel_mark;
                            n_res.destroy    = rel_destroy;
                        end
                        CMD_MARK: begin
                            ram_we           = 1'b1;
                            ram_wdata.mark   = 1'b1;
                            n_res.needs_load = 1'b0;
                        end
                        default: begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                // Hold until the output register is empty or draining this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_hit       <= n_hit;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (valid_set) begin
                r_valid[valid_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_ptr       <= n_ptr;
        r_rd_addr   <= ram_raddr;
        r_hit_slot  <= n_hit_slot;
        r_hit_cnt   <= n_hit_cnt;
        r_hit_mark  <= n_hit_mark;
        r_free_slot <= n_free_slot;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

@@ hw/rtl/rce_checker.sv @@
// Port-level checker for the reference-counted entry cache, bound to the top level.
module rce_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rce_pkg::t_out_item  o_out_data
);
    import rce_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // One command at a time: a transfer in closes the input side next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command taken while busy");

    // A full table answers with everything else cleared.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL)) |->
        (o_out_data.result_slot == '0 && !o_out_data.found_existing &&
         !o_out_data.needs_load && !o_out_data.destroy))
        else $error("table-full result carries slot data");

    // Destroy comes only from a successful release, which leaves the mark clear.
    a_destroy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.destroy) |->
        (o_out_data.status == ST_OK && o_out_data.needs_load &&
         !o_out_data.found_existing))
        else $error("destroy with bad status or mark");

endmodule

bind refcounted_entry_cache rce_checker u_rce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
